### rtl/core/oets_pkg.sv
// ----------------------------------------------------------------------------
// oets_pkg
// Shared types and constants of the odd-even transposition sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package oets_pkg;

    localparam int MAX_COUNT  = 64;
    localparam int DATA_W     = 32;
    localparam int CNT_W      = $clog2(MAX_COUNT + 1);
    localparam int IDX_W      = $clog2(MAX_COUNT);
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     batch_end;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     final_flag;
        logic                     dropped_flag;
    } t_out_item;

    // item after classification by the front end
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     batch_end;
        logic                     keep;
    } t_entry;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

### rtl/core/odd_even_transposition_sorter.sv
// ----------------------------------------------------------------------------
// odd_even_transposition_sorter
// Batch sorter for signed 32-bit values using odd-even transposition.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  input    | push / full        | i_item   : value, batch_end
//  result   | empty / pop        | o_result : sorted_value, final_flag,
//           |                    |            dropped_flag
//
// Load takes beats from the front queue, so beats of a batch stream in at one
// per cycle while the queue holds any. Sorting runs one exchange phase per cycle
// over the cell row; emit is one beat per cycle while pop is held.
// Reset is synchronous; the queue holds four beats, so push stalls while the
// engine sorts or emits and the queue has filled.
// ----------------------------------------------------------------------------
`default_nettype none

module odd_even_transposition_sorter (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire oets_pkg::t_in_item i_item,
    output logic                    empty,
    input  wire logic               pop,
    output oets_pkg::t_out_item     o_result
);

    logic             w_q_wr;
    logic             w_q_rd;
    logic             w_q_full;
    logic             w_q_empty;
    oets_pkg::t_entry w_wentry;
    oets_pkg::t_entry w_rentry;

    assign full = w_q_full;

    oets_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .i_item   (i_item),
        .i_q_full (w_q_full),
        .o_q_wr   (w_q_wr),
        .o_entry  (w_wentry)
    );

    oets_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_q_wr),
        .i_wdata (w_wentry),
        .i_rd    (w_q_rd),
        .o_rdata (w_rentry),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    oets_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_entry   (w_rentry),
        .i_q_empty (w_q_empty),
        .o_q_rd    (w_q_rd),
        .o_result  (o_result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

`default_nettype wire

### rtl/core/oets_front.sv
// ----------------------------------------------------------------------------
// oets_front
// Input front end: takes beats and marks each as kept or dropped by capacity.
// ----------------------------------------------------------------------------
`default_nettype none

module oets_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    input  wire oets_pkg::t_in_item i_item,
    input  wire logic              i_q_full,
    output logic                   o_q_wr,
    output oets_pkg::t_entry       o_entry
);

    logic [oets_pkg::CNT_W-1:0] r_count;
    logic [oets_pkg::CNT_W-1:0] n_count;
    logic                       w_keep;

    assign w_keep = (r_count < oets_pkg::CNT_W'(oets_pkg::MAX_COUNT));
    assign o_q_wr = push && !i_q_full;

    always_comb begin
        o_entry.value     = i_item.value;
        o_entry.batch_end = i_item.batch_end;
        o_entry.keep      = w_keep;
    end

    always_comb begin
        n_count = r_count;
        if (o_q_wr) begin
            if (i_item.batch_end) begin
                n_count = '0;
            end else if (w_keep) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

### rtl/core/oets_fifo.sv
// ----------------------------------------------------------------------------
// oets_fifo
// Short queue of classified beats between the front end and the sort engine.
// ----------------------------------------------------------------------------
`default_nettype none

module oets_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_wr,
    input  wire oets_pkg::t_entry i_wdata,
    input  wire logic            i_rd,
    output oets_pkg::t_entry     o_rdata,
    output logic                 o_full,
    output logic                 o_empty
);

    oets_pkg::t_entry           r_mem [oets_pkg::FIFO_DEPTH];
    logic [oets_pkg::FIFO_AW:0] r_wptr;
    logic [oets_pkg::FIFO_AW:0] r_rptr;

    assign o_empty = (r_wptr == r_rptr);
    assign o_full  = (r_wptr[oets_pkg::FIFO_AW-1:0] == r_rptr[oets_pkg::FIFO_AW-1:0])
                  && (r_wptr[oets_pkg::FIFO_AW] != r_rptr[oets_pkg::FIFO_AW]);
    assign o_rdata = r_mem[r_rptr[oets_pkg::FIFO_AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_wr && !o_full) begin
            r_mem[r_wptr[oets_pkg::FIFO_AW-1:0]] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
        end else begin
            if (i_wr && !o_full) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_rd && !o_empty) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/oets_back.sv
// ----------------------------------------------------------------------------
// oets_back
// Sort engine: loads a row of cells, runs one exchange phase per cycle,
// then shifts the sorted row out from cell 0.
// ----------------------------------------------------------------------------
`default_nettype none

module oets_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire oets_pkg::t_entry i_entry,
    input  wire logic             i_q_empty,
    output logic                  o_q_rd,
    output oets_pkg::t_out_item   o_result,
    output logic                  empty,
    input  wire logic             pop
);

    localparam int N = oets_pkg::MAX_COUNT;

    oets_pkg::t_state                  r_state, n_state;
    logic [oets_pkg::CNT_W-1:0]        r_count, n_count;
    logic                              r_odd, n_odd;
    logic                              r_quiet, n_quiet;
    logic                              r_drop, n_drop;
    logic signed [oets_pkg::DATA_W-1:0] r_cell [N];
    logic signed [oets_pkg::DATA_W-1:0] n_cell [N];
    logic [N-2:0]                      w_swap;
    logic                              w_any_swap;
    logic                              w_load;
    logic                              w_shift;

    // pair (i, i+1) exchanges in the phase of its parity, inside the batch
    for (genvar i = 0; i < N - 1; i++) begin : g_pair
        assign w_swap[i] = (r_state == oets_pkg::ST_SORT)
                        && (((i % 2) == 0) ? !r_odd : r_odd)
                        && (oets_pkg::CNT_W'(i + 1) < r_count)
                        && (r_cell[i] > r_cell[i + 1]);
    end

    assign w_any_swap = |w_swap;
    assign w_load     = o_q_rd && i_entry.keep;
    assign w_shift    = (r_state == oets_pkg::ST_EMIT) && pop;

    for (genvar k = 0; k < N; k++) begin : g_cell
        always_comb begin
            n_cell[k] = r_cell[k];
            if (w_load && (r_count[oets_pkg::IDX_W-1:0] == oets_pkg::IDX_W'(k))) begin
                n_cell[k] = i_entry.value;
            end else if (w_shift) begin
                if (k < N - 1) begin
                    n_cell[k] = r_cell[(k < N - 1) ? k + 1 : k];
                end
            end else begin
                if (k > 0) begin
                    if (w_swap[(k > 0) ? k - 1 : 0]) begin
                        n_cell[k] = r_cell[(k > 0) ? k - 1 : 0];
                    end
                end
                if (k < N - 1) begin
                    if (w_swap[(k < N - 1) ? k : 0]) begin
                        n_cell[k] = r_cell[(k < N - 1) ? k + 1 : k];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_odd   = r_odd;
        n_quiet = r_quiet;
        n_drop  = r_drop;
        o_q_rd  = 1'b0;
        unique case (r_state)
            oets_pkg::ST_LOAD: begin
                o_q_rd = !i_q_empty;
                if (!i_q_empty) begin
                    if (i_entry.keep) begin
                        n_count = r_count + 1'b1;
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_entry.batch_end) begin
                        n_state = oets_pkg::ST_SORT;
                        n_odd   = 1'b0;
                        n_quiet = 1'b0;
                    end
                end
            end
            oets_pkg::ST_SORT: begin
                n_odd   = !r_odd;
                n_quiet = !w_any_swap;
                // two quiet phases in a row: every neighbor pair is ordered
                if (!w_any_swap && r_quiet) begin
                    n_state = oets_pkg::ST_EMIT;
                end
            end
            oets_pkg::ST_EMIT: begin
                if (pop) begin
                    n_count = r_count - 1'b1;
                    if (r_count == oets_pkg::CNT_W'(1)) begin
                        n_state = oets_pkg::ST_LOAD;
                        n_drop  = 1'b0;
                    end
                end
            end
            default: begin
                n_state = oets_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= oets_pkg::ST_LOAD;
            r_count <= '0;
            r_odd   <= 1'b0;
            r_quiet <= 1'b0;
            r_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_odd   <= n_odd;
            r_quiet <= n_quiet;
            r_drop  <= n_drop;
        end
    end

    assign empty = (r_state != oets_pkg::ST_EMIT);

    always_comb begin
        o_result.sorted_value = r_cell[0];
        o_result.final_flag   = (r_count == oets_pkg::CNT_W'(1));
        o_result.dropped_flag = r_drop;
    end

    a_swap_only_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != oets_pkg::ST_SORT) |-> (w_swap == '0))
        else $error("exchange outside sort phase");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= oets_pkg::CNT_W'(oets_pkg::MAX_COUNT))
        else $error("element count above capacity");

    a_emit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == oets_pkg::ST_EMIT) |-> (r_count != '0))
        else $error("emitting with no elements");

    a_batch_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_shift && (r_count == oets_pkg::CNT_W'(1)))
        |=> ((r_state == oets_pkg::ST_LOAD) && (r_count == '0) && !r_drop))
        else $error("batch state not cleared after final beat");

endmodule

`default_nettype wire
